/* sv/crr_pkg.sv */
// Shared types and constants for the cache way replacement rank keeper.
// Depends on nothing; every other file takes what it needs by scoped names.
package crr_pkg;

    localparam int RANK_W = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
    localparam logic [RANK_W-1:0] RANK_NEWEST = 3'd1;

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Command codes carried on the command port.
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Replacement policy codes held in the policy register.
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;
    localparam logic [1:0] POL_LRU = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic execute;
        logic sweep;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic sweep_last;
    } dp_status_t;

endpackage

/* sv/crr_cfg.sv */
// Configuration register file behind an APB-style port.
// Depends on crr_pkg for the policy codes.
module crr_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  policy_select,
    output logic [2:0]  ways_in_use
);

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_WAYS = 1'b1;
    localparam logic [2:0] WAYS_RESET = 3'd4;

    logic [1:0] policy_select_reg;
    logic [2:0] ways_in_use_reg;
    logic       write_en;

    assign pready = 1'b1;
    assign write_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_select_reg <= crr_pkg::POL_LRU;
            ways_in_use_reg <= WAYS_RESET;
        end
        else if (write_en)
        begin
            unique case (paddr[2])
                REG_POLICY: policy_select_reg <= pwdata[1:0];
                REG_WAYS:   ways_in_use_reg <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POLICY: prdata = {30'b0, policy_select_reg};
            REG_WAYS:   prdata = {29'b0, ways_in_use_reg};
            default:    prdata = '0;
        endcase
    end

    assign policy_select = policy_select_reg;
    assign ways_in_use = ways_in_use_reg;

endmodule

/* sv/crr_ctrl.sv */
// Controller state machine: accepts commands, sequences execution and clearing sweeps.
// Depends on crr_pkg for command codes and the command and status structs.
module crr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             command,
    input  crr_pkg::dp_status_t    status,
    output crr_pkg::ctrl_cmd_t     ctrl,
    output logic                   busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy = (state_reg != S_IDLE);
    assign ctrl.accept = start && (state_reg == S_IDLE);
    assign ctrl.execute = (state_reg == S_EXEC);
    assign ctrl.sweep = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (command == crr_pkg::CMD_CLEAR) ? S_CLEAR : S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reset starts a sweep so that both rank stores read as zero afterwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.accept, ctrl.execute, ctrl.sweep}))
        else $error("controller issued more than one command at once");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> busy)
        else $error("busy not raised after a transfer was accepted");

    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg != S_EXEC))
        else $error("execution lasted more than one cycle");

    a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.sweep && !status.sweep_last) |=> ctrl.sweep)
        else $error("clearing sweep ended before the last row");
`endif

endmodule

/* sv/crr_datapath.sv */
// Datapath: rank row memories, row ageing, victim search, LFSR and result registers.
// Depends on crr_pkg for codes, rank constants and the command and status structs.
module crr_datapath #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crr_pkg::ctrl_cmd_t     ctrl,
    output crr_pkg::dp_status_t    status,
    input  logic [1:0]             command,
    input  logic [5:0]             set_index,
    input  logic [1:0]             way_index,
    input  logic                   access_hit,
    input  logic [1:0]             policy_select,
    input  logic [2:0]             ways_in_use,
    output logic                   result_strobe,
    output logic [1:0]             victim_way,
    output logic                   victim_found
);

    localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW = crr_pkg::RANK_W;
    localparam int ROW_W = WAYS * RW;

    typedef logic [RW-1:0] rank_t;

    // Residue helpers: fold digits whose radix is congruent to one, then trim.
    function automatic logic [2:0] mod3_16(input logic [15:0] x);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6])
          + 5'(x[9:8]) + 5'(x[11:10]) + 5'(x[13:12]) + 5'(x[15:14]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6)
        begin
            t = t - 3'd6;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t;
    endfunction

    function automatic logic [2:0] mod5_16(input logic [15:0] x);
        logic [5:0] s;
        logic [4:0] t;
        s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
        t = 5'(s[3:0]) + 5'(s[5:4]);
        if (t >= 5'd10)
        begin
            t = t - 5'd10;
        end
        if (t >= 5'd5)
        begin
            t = t - 5'd5;
        end
        return t[2:0];
    endfunction

    function automatic logic [2:0] mod7_16(input logic [15:0] x);
        logic [5:0] s;
        logic [3:0] t;
        s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
          + 6'(x[14:12]) + 6'(x[15]);
        t = 4'(s[2:0]) + 4'(s[5:3]);
        if (t >= 4'd7)
        begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    function automatic rank_t age_rank(input rank_t v, input rank_t cur,
                                       input logic active, input logic touched);
        rank_t r;
        r = v;
        if (touched)
        begin
            r = crr_pkg::RANK_NEWEST;
        end
        else if (active && (v != '0) && ((v < cur) || (cur == '0))
                 && (v != crr_pkg::RANK_MAX))
        begin
            r = v + rank_t'(1);
        end
        return r;
    endfunction

    logic [ROW_W-1:0] acc_mem [SETS];
    logic [ROW_W-1:0] plc_mem [SETS];

    logic [ADDR_W+5:0] set_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              set_ok;

    logic [1:0]        cmd_reg;
    logic [1:0]        way_reg;
    logic              hit_reg;
    logic              set_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ROW_W-1:0]  acc_row_reg;
    logic [ROW_W-1:0]  plc_row_reg;

    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic [crr_pkg::LFSR_W-1:0] lfsr_reg;
    logic [crr_pkg::LFSR_W-1:0] lfsr_next;
    logic              lfsr_fb;

    logic              result_strobe_reg;
    logic [1:0]        victim_way_reg;
    logic              victim_found_reg;

    rank_t             acc_old [WAYS];
    rank_t             plc_old [WAYS];
    logic [WAYS-1:0]   active;
    logic [WAYS-1:0]   touched;
    rank_t             acc_cur;
    rank_t             plc_cur;
    logic [ROW_W-1:0]  acc_wdata;
    logic [ROW_W-1:0]  plc_aged;
    logic [ROW_W-1:0]  plc_wdata;
    logic              way_ok;
    logic              upd_en;
    logic              is_query;
    logic              lfsr_shift;

    logic [2:0]        n_act;
    logic [2:0]        rnd_res;
    logic [2:0]        r3;
    logic              acc_found;
    logic [1:0]        acc_way;
    logic              plc_found;
    logic [1:0]        plc_way;
    logic              q_found;
    logic [1:0]        q_way;

    assign set_ext = {{ADDR_W{1'b0}}, set_index};
    assign rd_addr = set_ext[ADDR_W-1:0];
    assign set_ok = (int'(set_index) < SETS);

    // Capture the item and read both rank rows of its set.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= command;
            way_reg <= way_index;
            hit_reg <= access_hit;
            set_ok_reg <= set_ok;
            addr_reg <= rd_addr;
            acc_row_reg <= acc_mem[rd_addr];
            plc_row_reg <= plc_mem[rd_addr];
        end
    end

    // Row ageing, one lane per way.
    always_comb
    begin
        acc_cur = '0;
        plc_cur = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            acc_old[i] = acc_row_reg[i*RW +: RW];
            plc_old[i] = plc_row_reg[i*RW +: RW];
            active[i] = (int'(ways_in_use) > i);
            touched[i] = (int'(way_reg) == i);
            if (touched[i])
            begin
                acc_cur = acc_cur | acc_old[i];
                plc_cur = plc_cur | plc_old[i];
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            acc_wdata[i*RW +: RW] = age_rank(acc_old[i], acc_cur, active[i], touched[i]);
            plc_aged[i*RW +: RW] = age_rank(plc_old[i], plc_cur, active[i], touched[i]);
        end
    end

    assign plc_wdata = hit_reg ? plc_row_reg : plc_aged;
    assign way_ok = (int'(way_reg) < WAYS);
    assign upd_en = ctrl.execute && (cmd_reg == crr_pkg::CMD_UPDATE) && set_ok_reg
                    && way_ok && (ways_in_use > 3'd1);
    assign is_query = ctrl.execute && (cmd_reg == crr_pkg::CMD_QUERY);

    always_ff @(posedge clk)
    begin
        if (ctrl.sweep)
        begin
            acc_mem[sweep_cnt_reg] <= '0;
            plc_mem[sweep_cnt_reg] <= '0;
        end
        else if (upd_en)
        begin
            acc_mem[addr_reg] <= acc_wdata;
            plc_mem[addr_reg] <= plc_wdata;
        end
    end

    assign status.sweep_last = (sweep_cnt_reg == ADDR_W'(SETS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (ctrl.sweep)
        begin
            sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + ADDR_W'(1);
        end
    end

    // Oldest-way search: the lowest active way whose rank equals ways_in_use.
    always_comb
    begin
        acc_found = 1'b0;
        acc_way = '0;
        plc_found = 1'b0;
        plc_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (active[i] && (acc_old[i] == ways_in_use))
            begin
                acc_found = 1'b1;
                acc_way = 2'(i);
            end
            if (active[i] && (plc_old[i] == ways_in_use))
            begin
                plc_found = 1'b1;
                plc_way = 2'(i);
            end
        end
    end

    // Random victim: the LFSR value reduced modulo the active way count.
    assign n_act = (int'(ways_in_use) > WAYS) ? 3'(WAYS) : ways_in_use;
    assign r3 = mod3_16(lfsr_reg);

    always_comb
    begin
        unique case (n_act)
            3'd2:    rnd_res = {2'b0, lfsr_reg[0]};
            3'd3:    rnd_res = r3;
            3'd4:    rnd_res = {1'b0, lfsr_reg[1:0]};
            3'd5:    rnd_res = mod5_16(lfsr_reg);
            3'd6:    rnd_res = (r3[0] == lfsr_reg[0]) ? r3 : r3 + 3'd3;
            3'd7:    rnd_res = mod7_16(lfsr_reg);
            default: rnd_res = '0;
        endcase
    end

    always_comb
    begin
        q_found = 1'b0;
        q_way = '0;
        if (set_ok_reg)
        begin
            unique case (policy_select)
                crr_pkg::POL_RANDOM:
                begin
                    q_found = 1'b1;
                    q_way = rnd_res[1:0];
                end
                crr_pkg::POL_FIFO:
                begin
                    q_found = plc_found;
                    q_way = plc_way;
                end
                crr_pkg::POL_LRU:
                begin
                    q_found = acc_found;
                    q_way = acc_way;
                end
                default:
                begin
                    q_found = 1'b0;
                    q_way = '0;
                end
            endcase
        end
    end

    assign lfsr_shift = is_query && set_ok_reg && (policy_select == crr_pkg::POL_RANDOM);
    assign lfsr_fb = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_next = {lfsr_fb, lfsr_reg[crr_pkg::LFSR_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= crr_pkg::LFSR_SEED;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            if (lfsr_shift)
            begin
                lfsr_reg <= lfsr_next;
            end
            result_strobe_reg <= is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            victim_way_reg <= q_way;
            victim_found_reg <= q_found;
        end
    end

    assign result_strobe = result_strobe_reg;
    assign victim_way = victim_way_reg;
    assign victim_found = victim_found_reg;

`ifndef SYNTHESIS
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe_reg |-> $past(ctrl.execute))
        else $error("result strobed without an executed query");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR fell into the all-zero state");
`endif

endmodule

/* sv/cache_way_replacement_ranks.sv */
// Top level of the cache way replacement rank keeper.
// Depends on crr_pkg, crr_cfg, crr_ctrl and crr_datapath.
// A query is registered when start is taken, and its result is registered in the execute state.
// Busy stays high while an update or query executes, so no new command is taken until it is done.
// A clear zeroes the rank memories one row per cycle.
// Reset starts the same clearing sweep, with busy high; results cannot be stalled.
module cache_way_replacement_ranks #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [5:0]  set_index,
    input  logic [1:0]  way_index,
    input  logic        access_hit,
    output logic        result_strobe,
    output logic [1:0]  victim_way,
    output logic        victim_found
);

    // The block keeps two rank stores, each a memory of one row per set with
    // one rank per way. Access ranks follow every update and drive LRU; placement
    // ranks follow only misses and drive FIFO. Rank 0 marks an empty way and
    // rank 1 the newest.

    crr_pkg::ctrl_cmd_t  ctrl;
    crr_pkg::dp_status_t status;
    logic [1:0]          policy_select;
    logic [2:0]          ways_in_use;

    // Configuration registers are written by an APB transfer; they are only
    // expected to change while the block is idle.
    crr_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .policy_select (policy_select),
        .ways_in_use   (ways_in_use)
    );

    // The controller takes a transfer when start is high and busy is low. An
    // update or query then executes in the execute state; a clear runs the
    // row-by-row sweep.
    crr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    // The datapath reads both rows of the addressed set on acceptance, then in
    // the execute cycle either writes the aged rows back or registers the victim.
    crr_datapath #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .command       (command),
        .set_index     (set_index),
        .way_index     (way_index),
        .access_hit    (access_hit),
        .policy_select (policy_select),
        .ways_in_use   (ways_in_use),
        .result_strobe (result_strobe),
        .victim_way    (victim_way),
        .victim_found  (victim_found)
    );

endmodule

/* tb/tb_cache_way_replacement_ranks.sv */
// Self-checking testbench for the cache way replacement rank keeper.
// Depends on crr_pkg and the cache_way_replacement_ranks top level; needs no other file.
module tb_cache_way_replacement_ranks;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS = 4;
    localparam int SETS = 64;

    // The command and policy codes that the block must ignore have no name in the package.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    // Register indexes; each register sits at byte address 4 * index.
    localparam int REG_POLICY = 0;
    localparam int REG_WAYS = 1;

    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 145;

    // A clear sweeps every set row, so this is the longest the block can stay at work
    // once the last query result has been seen.
    localparam int SETTLE_CYCLES = SETS + 8;
    localparam int DRAIN_LIMIT = 2000;

    typedef logic [WAYS-1:0][crr_pkg::RANK_W-1:0] rank_row_t;

    typedef struct packed {
        logic [1:0] way;
        logic       found;
    } victim_t;

    // The scoreboard carries its own copy of both rank stores, the LFSR and the two
    // registers. Every accepted command moves that copy on, and every query leaves the
    // victim it should produce at the back of a queue.
    class rank_scoreboard;
        rank_row_t                  access_ranks [SETS];
        rank_row_t                  placement_ranks [SETS];
        logic [crr_pkg::LFSR_W-1:0] lfsr;
        logic [1:0]                 policy;
        logic [2:0]                 ways_reg;
        victim_t                    victims_due [$];
        int unsigned                mismatches;

        function new();
            clear_ranks();
            lfsr = crr_pkg::LFSR_SEED;
            policy = crr_pkg::POL_LRU;
            ways_reg = 3'd4;
            mismatches = 0;
        endfunction

        function void clear_ranks();
            foreach (access_ranks[s])
            begin
                access_ranks[s] = '0;
                placement_ranks[s] = '0;
            end
        endfunction

        function void write_register(int idx, logic [31:0] data);
            if (idx == REG_POLICY)
                policy = data[1:0];
            else if (idx == REG_WAYS)
                ways_reg = data[2:0];
        endfunction

        function int active_count();
            return (ways_reg > WAYS) ? WAYS : int'(ways_reg);
        endfunction

        // Ages every live rank younger than the touched way, then makes the touched way newest.
        function rank_row_t aged(rank_row_t row, int n, int way);
            rank_row_t                  next;
            logic [crr_pkg::RANK_W-1:0] touched;
            next = row;
            touched = row[way];
            for (int i = 0; i < n; i++)
            begin
                if (row[i] != '0 && (row[i] < touched || touched == '0)
                    && row[i] < crr_pkg::RANK_MAX)
                    next[i] = row[i] + 1'b1;
            end
            next[way] = crr_pkg::RANK_NEWEST;
            return next;
        endfunction

        function victim_t oldest(rank_row_t row, int n);
            victim_t v;
            v = '0;
            for (int i = n - 1; i >= 0; i--)
            begin
                if (row[i] == ways_reg)
                begin
                    v.way = 2'(i);
                    v.found = 1'b1;
                end
            end
            return v;
        endfunction

        function void note_command(logic [1:0] cmd, logic [5:0] set_i, logic [1:0] way,
                                   logic hit);
            int      n;
            victim_t v;
            n = active_count();
            v = '0;
            case (cmd)
                crr_pkg::CMD_UPDATE:
                begin
                    if (n > 1)
                    begin
                        access_ranks[set_i] = aged(access_ranks[set_i], n, way);
                        if (!hit)
                            placement_ranks[set_i] = aged(placement_ranks[set_i], n, way);
                    end
                end
                crr_pkg::CMD_QUERY:
                begin
                    case (policy)
                        crr_pkg::POL_RANDOM:
                        begin
                            v.way = (n == 0) ? 2'd0 : 2'(lfsr % n);
                            v.found = 1'b1;
                            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5],
                                    lfsr[crr_pkg::LFSR_W-1:1]};
                        end
                        crr_pkg::POL_FIFO: v = oldest(placement_ranks[set_i], n);
                        crr_pkg::POL_LRU: v = oldest(access_ranks[set_i], n);
                        default: v = '0;
                    endcase
                    victims_due = {victims_due, v};
                end
                crr_pkg::CMD_CLEAR: clear_ranks();
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_victim(logic [1:0] way, logic found);
            victim_t want;
            if (victims_due.size() == 0)
                report_mismatch($sformatf("result with no query waiting: way %0d found %b",
                                          way, found));
            else
            begin
                want = victims_due.pop_front();
                if (way !== want.way)
                    report_mismatch($sformatf("victim_way %0d, wanted %0d", way, want.way));
                if (found !== want.found)
                    report_mismatch($sformatf("victim_found %b, wanted %b", found, want.found));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [5:0]  set_index;
    logic [1:0]  way_index;
    logic        access_hit;
    logic        result_strobe;
    logic [1:0]  victim_way;
    logic        victim_found;

    rank_scoreboard board;

    // A small pool of sets per phase, so that rows are filled and aged deeply
    // rather than touched once and forgotten.
    logic [5:0] hot_sets [4];

    cache_way_replacement_ranks #(
        .WAYS(WAYS),
        .SETS(SETS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .command(command),
        .set_index(set_index),
        .way_index(way_index),
        .access_hit(access_hit),
        .result_strobe(result_strobe),
        .victim_way(victim_way),
        .victim_found(victim_found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is a completed transfer and is checked
    // at the rising edge that closes its cycle. Values read here are those from before
    // the edge, as the block's own registers only move in the update region.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
            board.check_victim(victim_way, victim_found);
    end

    // Write one register with a setup and an access cycle. The copy held by the scoreboard
    // changes at the very edge at which the block takes the write.
    task automatic apb_write(input int idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        board.write_register(idx, data);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input int idx, input logic [31:0] want);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== want)
            board.report_mismatch($sformatf("register %0d reads %h, wanted %h", idx, prdata, want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one command and hold it until the block takes it, that is, until a rising
    // edge finds busy low. Start is left high so that a following command can be offered
    // in the very next cycle without start dropping in between.
    task automatic send_item(input logic [1:0] cmd, input logic [5:0] set_i,
                             input logic [1:0] way, input logic hit);
        @(negedge clk);
        start <= 1'b1;
        command <= cmd;
        set_index <= set_i;
        way_index <= way;
        access_hit <= hit;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_command(cmd, set_i, way, hit);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Most gaps are short, a few are long, and one in two transfers follows straight on.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 82)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Stop offering commands and wait until every query sent so far has answered.
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (board.victims_due.size() != 0)
            @(posedge clk);
    endtask

    // Updates and clears give no result, so after the last answer the block may still be
    // sweeping its rows; let a full sweep pass and then wait for busy to fall as well.
    task automatic wait_for_idle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] policy, input logic [2:0] ways);
        wait_for_idle();
        apb_write(REG_POLICY, {30'd0, policy});
        apb_write(REG_WAYS, {29'd0, ways});
        apb_read_check(REG_POLICY, {30'd0, board.policy});
        apb_read_check(REG_WAYS, {29'd0, board.ways_reg});
    endtask

    // Mostly well-formed traffic on the hot sets: updates that fill and age rows,
    // queries that read them back, and now and then a clear or an unknown command.
    task automatic random_item();
        int         r;
        logic [1:0] cmd;
        logic [5:0] set_i;
        r = $urandom_range(0, 99);
        if (r < 52)
            cmd = crr_pkg::CMD_UPDATE;
        else if (r < 94)
            cmd = crr_pkg::CMD_QUERY;
        else if (r < 97)
            cmd = crr_pkg::CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) < 8)
            set_i = hot_sets[$urandom_range(0, 3)];
        else
            set_i = 6'($urandom_range(0, SETS - 1));
        send_item(cmd, set_i, 2'($urandom_range(0, WAYS - 1)), 1'($urandom_range(0, 1)));
    endtask

    // The directed part walks the policies and the corner settings of the way count.
    task automatic run_directed();
        // LRU over all four ways: fill a row by misses, then read back the oldest way,
        // refresh it by a hit and read back again.
        configure(crr_pkg::POL_LRU, 3'd4);
        for (int w = 0; w < WAYS; w++)
            send_item(crr_pkg::CMD_UPDATE, 6'd63, 2'(w), 1'b0);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd0, 1'b0);
        send_item(crr_pkg::CMD_UPDATE, 6'd63, 2'd0, 1'b1);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd3, 1'b1);
        // A row touched only once holds no way at the oldest rank.
        send_item(crr_pkg::CMD_UPDATE, 6'd0, 2'd3, 1'b1);
        send_item(crr_pkg::CMD_QUERY, 6'd0, 2'd0, 1'b0);
        // An unknown command with every field at its top value must change nothing.
        send_item(CMD_UNUSED, 6'd63, 2'd3, 1'b1);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd0, 1'b0);

        // FIFO ignores the hit seen above; a clear then empties every row.
        configure(crr_pkg::POL_FIFO, 3'd4);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd1, 1'b0);
        send_item(crr_pkg::CMD_CLEAR, 6'd42, 2'd2, 1'b1);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd0, 1'b0);

        configure(crr_pkg::POL_RANDOM, 3'd4);
        send_item(crr_pkg::CMD_QUERY, 6'd0, 2'd0, 1'b0);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd3, 1'b1);
        send_item(crr_pkg::CMD_QUERY, 6'd21, 2'd2, 1'b0);

        // The unused policy code answers with no victim.
        configure(POL_UNUSED, 3'd4);
        send_item(crr_pkg::CMD_QUERY, 6'd63, 2'd0, 1'b0);

        // A single active way makes an update do nothing.
        configure(crr_pkg::POL_LRU, 3'd1);
        send_item(crr_pkg::CMD_UPDATE, 6'd5, 2'd1, 1'b0);
        send_item(crr_pkg::CMD_QUERY, 6'd5, 2'd0, 1'b0);

        // No active ways at all, under random and under FIFO.
        configure(crr_pkg::POL_RANDOM, 3'd0);
        send_item(crr_pkg::CMD_QUERY, 6'd5, 2'd0, 1'b0);
        configure(crr_pkg::POL_FIFO, 3'd0);
        send_item(crr_pkg::CMD_QUERY, 6'd5, 2'd0, 1'b0);

        // Two active ways with a touch of a way outside them.
        configure(crr_pkg::POL_FIFO, 3'd2);
        send_item(crr_pkg::CMD_UPDATE, 6'd9, 2'd3, 1'b0);
        send_item(crr_pkg::CMD_UPDATE, 6'd9, 2'd0, 1'b0);
        send_item(crr_pkg::CMD_UPDATE, 6'd9, 2'd1, 1'b0);
        send_item(crr_pkg::CMD_QUERY, 6'd9, 2'd0, 1'b0);

        // A way count above the number of ways: no rank ever reaches it.
        configure(crr_pkg::POL_LRU, 3'd7);
        send_item(crr_pkg::CMD_QUERY, 6'd9, 2'd0, 1'b0);
    endtask

    // The run ends here whatever else happens; it is several times the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [1:0] policy;
        logic [2:0] ways;
        bit         quiet;
        int         drained;
        board = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        command = crr_pkg::CMD_UPDATE;
        set_index = '0;
        way_index = '0;
        access_hit = 1'b0;
        hot_sets = '{6'd0, 6'd1, 6'd62, 6'd63};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Leaving reset, the block sweeps every row with busy high; wait it out.
        repeat (2) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // The first phases take the usual and the extreme settings in turn, and
            // the rest are drawn at random, weighted towards the useful way counts.
            case (p)
                0:
                begin
                    policy = crr_pkg::POL_LRU;
                    ways = 3'd4;
                end
                1:
                begin
                    policy = crr_pkg::POL_FIFO;
                    ways = 3'd4;
                end
                2:
                begin
                    policy = crr_pkg::POL_RANDOM;
                    ways = 3'd4;
                end
                3:
                begin
                    policy = crr_pkg::POL_LRU;
                    ways = 3'd2;
                end
                4:
                begin
                    policy = crr_pkg::POL_FIFO;
                    ways = 3'd3;
                end
                5:
                begin
                    policy = crr_pkg::POL_RANDOM;
                    ways = 3'd3;
                end
                6:
                begin
                    policy = crr_pkg::POL_LRU;
                    ways = 3'd5;
                end
                7:
                begin
                    policy = POL_UNUSED;
                    ways = 3'd2;
                end
                default:
                begin
                    policy = ($urandom_range(0, 9) == 0) ? POL_UNUSED : 2'($urandom_range(0, 2));
                    ways = ($urandom_range(0, 9) < 2) ? 3'($urandom_range(0, 7))
                                                      : 3'($urandom_range(2, 4));
                end
            endcase
            configure(policy, ways);

            for (int h = 0; h < 4; h++)
                hot_sets[h] = 6'($urandom_range(0, SETS - 1));
            quiet = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                random_item();
                if (!quiet)
                    pause(gap_length());
                // Now and then the sender holds back until every query has answered.
                if ((p == 0 && k == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
                    wait_for_results();
            end
        end

        // Let the last answers arrive, within a bound, and then a full sweep more so
        // that any stray strobe would still be caught by the monitor.
        @(negedge clk);
        start <= 1'b0;
        drained = 0;
        while (board.victims_due.size() != 0 && drained < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.victims_due.size() != 0)
            board.report_mismatch($sformatf("%0d query results never arrived",
                                            board.victims_due.size()));

        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
